// ===== rtl/core/bss_pkg.sv =====
// Shared types and constants of the binned stream statistics block.
package bss_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_X_ORIGIN = 3'd1;
  localparam logic [2:0] REG_X_STEP   = 3'd2;
  localparam logic [2:0] REG_X_COUNT  = 3'd3;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd4;
  localparam logic [2:0] REG_Y_STEP   = 3'd5;
  localparam logic [2:0] REG_Y_COUNT  = 3'd6;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_X      = 2'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] value;
    logic [6:0]         read_x;
    logic [6:0]         read_y;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         bin_x;
    logic [6:0]         bin_y;
    logic [31:0]        tally;
    logic signed [47:0] total;
    logic [62:0]        total_squares;
    logic signed [15:0] smallest;
    logic signed [15:0] largest;
    logic signed [15:0] mean;
    logic [15:0]        deviation;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        tally;
    logic [47:0]        total;
    logic [62:0]        squares;
    logic signed [15:0] smallest;
    logic signed [15:0] largest;
  } bin_rec_t;

  localparam int RecW = $bits(bin_rec_t);

  localparam bin_rec_t EMPTY_REC = '{
    tally: 32'd0, total: 48'd0, squares: 63'd0,
    smallest: 16'sh7FFF, largest: -16'sh8000
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] x_origin;
    logic [15:0]        x_step;
    logic [6:0]         x_count;
    logic signed [15:0] y_origin;
    logic [15:0]        y_step;
    logic [6:0]         y_count;
  } cfg_t;

endpackage

// ===== rtl/core/bss_store.sv =====
// Single-port bin record memory with registered read data.
module bss_store import bss_pkg::*; #(
  parameter int Depth = 4225,
  parameter int AddrW = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  bin_rec_t         wdata_i,
  output bin_rec_t         rdata_o
);

  bin_rec_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== rtl/core/bss_mul.sv =====
// Shared 32 by 32 unsigned multiplier with a registered product.
module bss_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/bss_seq.sv =====
// Sequencer with the shared compare-subtract unit for binning, mean and deviation.
module bss_seq import bss_pkg::*; #(
  parameter int X_BINS_MAX = 64,
  parameter int Y_BINS_MAX = 64,
  parameter int AddrW = 13,
  parameter int Nbins = 4225
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_addr_o,
  output bin_rec_t         mem_wdata_o,
  input  bin_rec_t         mem_rdata_i,
  output logic [31:0]      mul_a_o,
  output logic [31:0]      mul_b_o,
  input  logic [63:0]      mul_p_i
);

  localparam int XW = $clog2(X_BINS_MAX + 1);
  localparam int YW = $clog2(Y_BINS_MAX + 1);
  localparam logic [AddrW-1:0] YSPAN = AddrW'(Y_BINS_MAX + 1);
  localparam logic [AddrW-1:0] LAST = AddrW'(Nbins - 1);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_BINX     = 4'd2;
  localparam logic [3:0] ST_BINY     = 4'd3;
  localparam logic [3:0] ST_ADD_RD   = 4'd4;
  localparam logic [3:0] ST_ADD_WAIT = 4'd5;
  localparam logic [3:0] ST_ADD_WR   = 4'd6;
  localparam logic [3:0] ST_RD_RD    = 4'd7;
  localparam logic [3:0] ST_RD_WAIT  = 4'd8;
  localparam logic [3:0] ST_PREP     = 4'd9;
  localparam logic [3:0] ST_MEAN     = 4'd10;
  localparam logic [3:0] ST_MUL      = 4'd11;
  localparam logic [3:0] ST_OVF      = 4'd12;
  localparam logic [3:0] ST_DEV      = 4'd13;
  localparam logic [3:0] ST_SQRT     = 4'd14;
  localparam logic [3:0] ST_OUT      = 4'd15;

  // Bin number from the quotient of (coordinate - origin) / step.
  function automatic logic [16:0] bin_pick(logic neg, logic [15:0] k, logic [6:0] cnt,
                                           int lim);
    logic [16:0] n_eff;
    n_eff = {10'd0, cnt};
    if (cnt == 7'd0) n_eff = 17'd1;
    else if (n_eff > 17'(lim)) n_eff = 17'(lim);
    if (neg || ({1'b0, k} >= n_eff)) return 17'd0;
    return {1'b0, k} + 17'd1;
  endfunction

  logic [3:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  in_item_t         item_q, item_d;
  logic [XW-1:0]    bx_q, bx_d;
  logic [YW-1:0]    by_q, by_d;
  bin_rec_t         rec_q, rec_d;
  logic             rd_ok_q, rd_ok_d;
  logic [31:0]      sqz_q, sqz_d;
  logic [63:0]      rem_q, rem_d;
  logic [47:0]      dvd_q, dvd_d;
  logic [47:0]      quo_q, quo_d;
  logic [63:0]      dvs_q, dvs_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [96:0]      acc_q, acc_d;
  logic [2:0]       mstep_q, mstep_d;
  logic [15:0]      mean_q, mean_d;
  logic [15:0]      dev_q, dev_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [64:0] sub_a, sub_b, sub_diff;
  logic        sub_ge;
  logic [16:0] dd_x, dd_y, dd_xi;
  logic [15:0] stx, sty;
  logic [47:0] mag;
  logic [15:0] absz;
  logic [AddrW-1:0] bin_addr, rd_addr;
  logic [96:0] term;
  bin_rec_t    upd;
  logic        sat;

  assign dd_xi = {in_item_i.coord_x[15], in_item_i.coord_x}
               - {cfg_i.x_origin[15], cfg_i.x_origin};
  assign dd_x  = {item_q.coord_x[15], item_q.coord_x} - {cfg_i.x_origin[15], cfg_i.x_origin};
  assign dd_y  = {item_q.coord_y[15], item_q.coord_y} - {cfg_i.y_origin[15], cfg_i.y_origin};
  assign stx   = (cfg_i.x_step == 16'd0) ? 16'd1 : cfg_i.x_step;
  assign sty   = (cfg_i.y_step == 16'd0) ? 16'd1 : cfg_i.y_step;
  assign mag   = rec_q.total[47] ? (48'd0 - rec_q.total) : rec_q.total;
  assign absz  = item_q.value[15] ? (16'd0 - item_q.value) : item_q.value;
  assign bin_addr = AddrW'(bx_q) * YSPAN + AddrW'(by_q);
  assign rd_addr  = AddrW'(item_q.read_x) * YSPAN + AddrW'(item_q.read_y);
  assign sat = &rec_q.tally;

  // Shared compare-subtract unit.
  always_comb begin
    case (state_q)
      ST_OVF:  begin sub_a = {1'b0, acc_q[95:32]}; sub_b = {1'b0, dvs_q}; end
      ST_SQRT: begin
        sub_a = {rem_q[62:0], dvd_q[47:46]};
        sub_b = {47'd0, quo_q[15:0], 2'b01};
      end
      default: begin sub_a = {rem_q, dvd_q[47]}; sub_b = {1'b0, dvs_q}; end
    endcase
  end
  assign sub_ge   = sub_a >= sub_b;
  assign sub_diff = sub_a - sub_b;

  always_comb begin
    upd = rec_q;
    upd.tally = rec_q.tally + 32'd1;
    upd.total = rec_q.total + {{32{item_q.value[15]}}, item_q.value};
    upd.squares = rec_q.squares + {31'd0, sqz_q};
    if (item_q.value < rec_q.smallest) upd.smallest = item_q.value;
    if (item_q.value > rec_q.largest) upd.largest = item_q.value;
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_addr_o  = bin_addr;
    mem_wdata_o = upd;
    case (state_q)
      ST_CLEAR: begin
        mem_we_o = 1'b1; mem_addr_o = clr_q; mem_wdata_o = EMPTY_REC;
      end
      ST_ADD_WR: mem_we_o = !sat;
      ST_RD_RD:  mem_addr_o = rd_addr;
      default: ;
    endcase
  end

  always_comb begin
    mul_a_o = {16'd0, absz};
    mul_b_o = {16'd0, absz};
    if (state_q == ST_MUL) begin
      case (mstep_q)
        3'd0: begin mul_a_o = rec_q.tally; mul_b_o = rec_q.squares[31:0]; end
        3'd1: begin mul_a_o = rec_q.tally; mul_b_o = {1'b0, rec_q.squares[62:32]}; end
        3'd2: begin mul_a_o = mag[31:0]; mul_b_o = mag[31:0]; end
        3'd3: begin mul_a_o = mag[31:0]; mul_b_o = {16'd0, mag[47:32]}; end
        3'd4: begin mul_a_o = {16'd0, mag[47:32]}; mul_b_o = mag[31:0]; end
        3'd5: begin mul_a_o = {16'd0, mag[47:32]}; mul_b_o = {16'd0, mag[47:32]}; end
        default: begin mul_a_o = rec_q.tally; mul_b_o = rec_q.tally - 32'd1; end
      endcase
    end
  end

  always_comb begin
    case (mstep_q)
      3'd2, 3'd4, 3'd5: term = {33'd0, mul_p_i} << 32;
      3'd6:             term = {33'd0, mul_p_i} << 64;
      default:          term = {33'd0, mul_p_i};
    endcase
  end

  always_comb begin
    state_d = state_q; clr_d = clr_q; item_d = item_q; bx_d = bx_q; by_d = by_q;
    rec_d = rec_q; rd_ok_d = rd_ok_q; sqz_d = sqz_q; rem_d = rem_q; dvd_d = dvd_q;
    quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q; acc_d = acc_q; mstep_d = mstep_q;
    mean_d = mean_q; dev_d = dev_q; out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    // One step of restoring division is the default use of the unit.
    if (state_q == ST_BINX || state_q == ST_BINY || state_q == ST_MEAN ||
        state_q == ST_DEV) begin
      rem_d = sub_ge ? sub_diff[63:0] : sub_a[63:0];
      quo_d = {quo_q[46:0], sub_ge};
      dvd_d = {dvd_q[46:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          bx_d = XW'(1);
          by_d = YW'(1);
          rem_d = 64'd0; quo_d = 48'd0; cnt_d = 6'd16;
          dvd_d = {dd_xi[15:0], 32'd0};
          dvs_d = {48'd0, stx};
          rd_ok_d = (32'(in_item_i.read_x) <= 32'(X_BINS_MAX)) &&
                    (32'(in_item_i.read_y) <= 32'(Y_BINS_MAX));
          case (in_item_i.command)
            CMD_ADD:   state_d = (cfg_i.mode == MODE_SINGLE) ? ST_ADD_RD : ST_BINX;
            CMD_READ:  state_d = ST_RD_RD;
            CMD_CLEAR: begin state_d = ST_CLEAR; clr_d = '0; end
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_BINX: begin
        if (cnt_q == 6'd1) begin
          bx_d = XW'(bin_pick(dd_x[16], quo_d[15:0], cfg_i.x_count, X_BINS_MAX));
          if (cfg_i.mode == MODE_X) begin
            state_d = ST_ADD_RD;
          end else begin
            rem_d = 64'd0; quo_d = 48'd0; cnt_d = 6'd16;
            dvd_d = {dd_y[15:0], 32'd0};
            dvs_d = {48'd0, sty};
            state_d = ST_BINY;
          end
        end
      end
      ST_BINY: begin
        if (cnt_q == 6'd1) begin
          by_d = YW'(bin_pick(dd_y[16], quo_d[15:0], cfg_i.y_count, Y_BINS_MAX));
          state_d = ST_ADD_RD;
        end
      end
      ST_ADD_RD:   state_d = ST_ADD_WAIT;
      ST_ADD_WAIT: begin
        rec_d = mem_rdata_i;
        sqz_d = mul_p_i[31:0];
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR:  state_d = ST_IDLE;
      ST_RD_RD:   state_d = ST_RD_WAIT;
      ST_RD_WAIT: begin
        rec_d = rd_ok_q ? mem_rdata_i : EMPTY_REC;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        rem_d = 64'd0; quo_d = 48'd0; cnt_d = 6'd48;
        dvd_d = mag;
        dvs_d = {32'd0, rec_q.tally};
        mstep_d = 3'd0; acc_d = '0; mean_d = 16'd0;
        state_d = (rec_q.tally == 32'd0) ? ST_MUL : ST_MEAN;
      end
      ST_MEAN: begin
        if (cnt_q == 6'd1) begin
          mean_d = rec_q.total[47] ? (16'd0 - quo_d[15:0]) : quo_d[15:0];
          mstep_d = 3'd0; acc_d = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mstep_d = mstep_q + 3'd1;
        case (mstep_q)
          3'd1, 3'd2: acc_d = acc_q + term;
          3'd0:       acc_d = acc_q;
          3'd7: begin
            dvs_d = mul_p_i;
            state_d = ST_OVF;
          end
          default:    acc_d = acc_q - term;
        endcase
      end
      ST_OVF: begin
        if (rec_q.tally < 32'd2 || acc_q[96]) begin
          dev_d = 16'd0; state_d = ST_OUT;
        end else if (sub_ge) begin
          dev_d = 16'hFFFF; state_d = ST_OUT;
        end else begin
          rem_d = acc_q[95:32]; dvd_d = {acc_q[31:0], 16'd0};
          quo_d = 48'd0; cnt_d = 6'd32;
          state_d = ST_DEV;
        end
      end
      ST_DEV: begin
        if (cnt_q == 6'd1) begin
          dvd_d = {quo_d[31:0], 16'd0};
          rem_d = 64'd0; quo_d = 48'd0; cnt_d = 6'd16;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rem_d = sub_ge ? sub_diff[63:0] : sub_a[63:0];
        quo_d = {quo_q[46:0], sub_ge};
        dvd_d = {dvd_q[45:0], 2'b00};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          dev_d = quo_d[15:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.bin_x = item_q.read_x;
          out_d.bin_y = item_q.read_y;
          out_d.tally = rec_q.tally;
          out_d.total = rec_q.total;
          out_d.total_squares = rec_q.squares;
          out_d.smallest = rec_q.smallest;
          out_d.largest = rec_q.largest;
          out_d.mean = mean_q;
          out_d.deviation = dev_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; bx_q <= bx_d; by_q <= by_d; rec_q <= rec_d; rd_ok_q <= rd_ok_d;
    sqz_q <= sqz_d; rem_q <= rem_d; dvd_q <= dvd_d; quo_q <= quo_d; dvs_q <= dvs_d;
    cnt_q <= cnt_d; acc_q <= acc_d; mstep_q <= mstep_d; mean_q <= mean_d;
    dev_q <= dev_d; out_q <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/binned_stream_statistics.sv =====
// Top level of the binned stream statistics block.
// Each item is one command: add a sample, read one bin, or clear all bins. Samples are
// binned on equal-width grids (bin 0 catches out-of-range coordinates) and every bin keeps
// count, sum, sum of squares, minimum and maximum in one single-port record memory of
// (X_BINS_MAX+1)*(Y_BINS_MAX+1) entries. Only a read produces a result item, carrying the
// totals, the truncated mean and the floor sample standard deviation. The block works on
// one item at a time and is not ready while it does. An add in the single-bin mode goes
// straight to the memory; binned by x, and by x and y, it first runs one or two 16-step
// divisions by the bin width in the shared compare-subtract unit. A read of a bin with two
// or more samples runs a 48-step division for the mean, a series of products on the shared
// 32 by 32 multiplier, a 32-step division and a 16-step square root, all on the same unit;
// a bin with one sample skips the division and the square root for the deviation, and an
// empty bin also skips the division for the mean. A read also waits while the previous
// result item has not yet been taken by the receiver. After reset and after a clear
// command the block sweeps the memory once, one entry per cycle, and takes no item
// meanwhile; configuration writes are taken at any time and are meant to be made only
// while the block is idle.
module binned_stream_statistics import bss_pkg::*; #(
  parameter int X_BINS_MAX = 64,
  parameter int Y_BINS_MAX = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int Nbins = (X_BINS_MAX + 1) * (Y_BINS_MAX + 1);
  localparam int AddrW = $clog2(Nbins);

  cfg_t cfg_q;

  // Configuration registers; a write to an unused index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 2'd0, x_origin: 16'sd0, x_step: 16'd1, x_count: 7'd1,
                 y_origin: 16'sd0, y_step: 16'd1, y_count: 7'd1};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:     cfg_q.mode <= cfg_data_i[1:0];
        REG_X_ORIGIN: cfg_q.x_origin <= cfg_data_i;
        REG_X_STEP:   cfg_q.x_step <= cfg_data_i;
        REG_X_COUNT:  cfg_q.x_count <= cfg_data_i[6:0];
        REG_Y_ORIGIN: cfg_q.y_origin <= cfg_data_i;
        REG_Y_STEP:   cfg_q.y_step <= cfg_data_i;
        REG_Y_COUNT:  cfg_q.y_count <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  bin_rec_t         mem_wdata, mem_rdata;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;

  bss_seq #(
    .X_BINS_MAX(X_BINS_MAX), .Y_BINS_MAX(Y_BINS_MAX), .AddrW(AddrW), .Nbins(Nbins)
  ) u_seq (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .mem_we_o(mem_we), .mem_addr_o(mem_addr), .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata),
    .mul_a_o(mul_a), .mul_b_o(mul_b), .mul_p_i(mul_p)
  );

  bss_store #(.Depth(Nbins), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wdata), .rdata_o(mem_rdata)
  );

  bss_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

endmodule
